// ===== rtl/kpc_pkg.sv =====
// Package for the key press classifier: beat structs, mode enum, codes.
// No dependencies; used by every file of the block.
package kpc_pkg;

    localparam int unsigned DEB_W  = 8;
    localparam int unsigned LONG_W = 16;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [IDX_W-1:0] CFG_LONG     = 1'b1;

    localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd2;
    localparam logic [LONG_W-1:0] LONG_RESET = 16'd150;

    // Key codes
    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_POWER = 2'd1;
    localparam logic [1:0] KEY_PAIR  = 2'd2;

    // Event kinds
    localparam logic [1:0] KIND_SHORT   = 2'd0;
    localparam logic [1:0] KIND_LONG    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DEBOUNCE = 2'd1,
        MODE_PRESSED  = 2'd2,
        MODE_LONG     = 2'd3
    } t_key_mode;

    typedef struct packed {
        logic power_key_level;
        logic pair_key_level;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] which_key;
        logic [1:0] press_kind;
        logic       blink_request;
    } t_out_beat;

    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_step_res;

endpackage

// ===== rtl/kpc_step.sv =====
// Per-tick classifier: mode/held key/wait counter registers and their update.
// Depends on kpc_pkg.
module kpc_step (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  kpc_pkg::t_in_beat            i_beat,
    input  logic [kpc_pkg::DEB_W-1:0]    i_debounce_scans,
    input  logic [kpc_pkg::LONG_W-1:0]   i_long_press_scans,
    output kpc_pkg::t_step_res           o_res
);

    kpc_pkg::t_key_mode          r_mode, n_mode;
    logic [1:0]                  r_held, n_held;
    logic [kpc_pkg::CNT_W-1:0]   r_wait, n_wait;
    logic [kpc_pkg::CNT_W-1:0]   wait_inc;
    logic [1:0]                  key;
    logic                        deb_done, long_done;

    // power key wins over pair key
    always_comb begin
        if (!i_beat.power_key_level) begin
            key = kpc_pkg::KEY_POWER;
        end else if (!i_beat.pair_key_level) begin
            key = kpc_pkg::KEY_PAIR;
        end else begin
            key = kpc_pkg::KEY_NONE;
        end
    end

    // saturating tick, then threshold compare
    assign wait_inc  = (r_wait == {kpc_pkg::CNT_W{1'b1}}) ? r_wait : r_wait + 1'b1;
    assign deb_done  = wait_inc >= {{(kpc_pkg::CNT_W-kpc_pkg::DEB_W){1'b0}}, i_debounce_scans};
    assign long_done = wait_inc >= i_long_press_scans;

    // next state
    always_comb begin
        n_mode = r_mode;
        n_held = r_held;
        n_wait = r_wait;
        unique case (r_mode)
            kpc_pkg::MODE_IDLE: begin
                if (key != kpc_pkg::KEY_NONE) begin
                    n_held = key;
                    n_wait = '0;
                    n_mode = (i_debounce_scans == '0) ? kpc_pkg::MODE_PRESSED
                                                      : kpc_pkg::MODE_DEBOUNCE;
                end
            end
            kpc_pkg::MODE_DEBOUNCE: begin
                if (key != r_held) begin
                    n_mode = kpc_pkg::MODE_IDLE;
                end else if (deb_done) begin
                    n_wait = '0;
                    n_mode = kpc_pkg::MODE_PRESSED;
                end else begin
                    n_wait = wait_inc;
                end
            end
            kpc_pkg::MODE_PRESSED: begin
                if (key != r_held) begin
                    n_mode = kpc_pkg::MODE_IDLE;
                end else if (long_done) begin
                    n_wait = '0;
                    n_mode = kpc_pkg::MODE_LONG;
                end else begin
                    n_wait = wait_inc;
                end
            end
            kpc_pkg::MODE_LONG: begin
                if (key != r_held) begin
                    n_mode = kpc_pkg::MODE_IDLE;
                end else begin
                    n_wait = long_done ? '0 : wait_inc;  // re-arm, silent
                end
            end
            default: n_mode = kpc_pkg::MODE_IDLE;
        endcase
    end

    // event output
    always_comb begin
        o_res                    = '0;
        o_res.beat.which_key     = r_held;
        unique case (r_mode)
            kpc_pkg::MODE_PRESSED: begin
                if (key != r_held) begin
                    o_res.valid           = 1'b1;
                    o_res.beat.press_kind = kpc_pkg::KIND_SHORT;
                end else if (long_done) begin
                    o_res.valid              = 1'b1;
                    o_res.beat.press_kind    = kpc_pkg::KIND_LONG;
                    o_res.beat.blink_request = 1'b1;
                end
            end
            kpc_pkg::MODE_LONG: begin
                if (key != r_held) begin
                    o_res.valid              = 1'b1;
                    o_res.beat.press_kind    = kpc_pkg::KIND_RELEASE;
                    o_res.beat.blink_request = 1'b1;
                end
            end
            default: o_res.valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= kpc_pkg::MODE_IDLE;
            r_held <= kpc_pkg::KEY_NONE;
            r_wait <= '0;
        end else if (i_advance) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_wait <= n_wait;
        end
    end

endmodule

// ===== rtl/key_press_classifier.sv =====
// Result beat path: input register, combinational step logic, result register;
// a stalled result register can hold a beat in the input register.
// Throughput: one scan tick per cycle; only a full, stalled result register holds input.
// Ticks that cause no event produce no output beat.
// Reset (synchronous, i_rst_n low): mode idle, held key and wait counter cleared,
// both pipeline registers empty, debounce_scans = 2, long_press_scans = 150.
// Top level of the key press classifier; depends on kpc_pkg and kpc_step.
module key_press_classifier (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // scan tick input
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  kpc_pkg::t_in_beat            i_in,
    // event output
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output kpc_pkg::t_out_beat           o_out,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [kpc_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [kpc_pkg::CFG_W-1:0]    i_cfg_data
);

    // Config registers
    logic [kpc_pkg::DEB_W-1:0]  r_debounce_scans;
    logic [kpc_pkg::LONG_W-1:0] r_long_press_scans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_scans   <= kpc_pkg::DEB_RESET;
            r_long_press_scans <= kpc_pkg::LONG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kpc_pkg::CFG_DEBOUNCE: r_debounce_scans   <= i_cfg_data[kpc_pkg::DEB_W-1:0];
                kpc_pkg::CFG_LONG:     r_long_press_scans <= i_cfg_data[kpc_pkg::LONG_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register stage
    logic              r_in_valid;
    kpc_pkg::t_in_beat r_in;
    logic              advance;     // input stage beat moves through the step logic

    // A held beat can only retire while the result slot is free or draining.
    assign advance    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Classification step: state update plus zero-or-one event
    kpc_pkg::t_step_res step_res;

    kpc_step u_step (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (advance),
        .i_beat             (r_in),
        .i_debounce_scans   (r_debounce_scans),
        .i_long_press_scans (r_long_press_scans),
        .o_res              (step_res)
    );

    // Result register
    logic               r_out_valid;
    kpc_pkg::t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.valid) begin
            r_out <= step_res.beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/kpc_checker.sv =====
// Port-level checks for the key press classifier, bound to the top level.
// Depends on kpc_pkg and key_press_classifier.
module kpc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input kpc_pkg::t_out_beat           o_out
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat dropped or changed while stalled");

    // blink goes with long press and release, never with short press
    a_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.blink_request == (o_out.press_kind != kpc_pkg::KIND_SHORT)))
        else $error("blink request does not match press kind");

    // event names a real key
    a_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.which_key == kpc_pkg::KEY_POWER ||
                         o_out.which_key == kpc_pkg::KEY_PAIR))
        else $error("event without a key");

    // input is never blocked while the result side is empty and draining
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && i_out_ready |-> o_in_ready)
        else $error("input stalled with free result slot");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
